FILE: sv/rgbe_pkg.sv
// shared constants, types and helpers for the rgbe encoder
package rgbe_pkg;

   localparam logic [31:0] THRESH_BITS  = 32'h3089_705F;
   localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
   localparam logic [7:0]  MIN_EXP_BYTE = 8'd99;

   typedef struct packed {
      logic advance;
   } pipe_ctrl_type;

   function automatic logic [31:0] order_key(input logic [31:0] bits);
      order_key = bits[31] ? ~bits : (bits | 32'h8000_0000);
   endfunction

   function automatic logic is_nan(input logic [31:0] bits);
      is_nan = ({1'b0, bits[30:0]} > POS_INF_BITS);
   endfunction

endpackage

FILE: sv/rgbe_max.sv
// maximum search and black pixel detection over the three components
module rgbe_max import rgbe_pkg::*; (
   input  logic [31:0] red_bits,
   input  logic [31:0] green_bits,
   input  logic [31:0] blue_bits,
   output logic [7:0]  max_field,
   output logic        black
);

   logic [31:0] key_rg;
   logic [31:0] bits_rg;
   logic [31:0] max_bits;
   logic        any_nan;

   always_comb begin
      if (order_key(green_bits) > order_key(red_bits)) begin
         key_rg  = order_key(green_bits);
         bits_rg = green_bits;
      end else begin
         key_rg  = order_key(red_bits);
         bits_rg = red_bits;
      end
      max_bits = (order_key(blue_bits) > key_rg) ? blue_bits : bits_rg;
      any_nan  = is_nan(red_bits) | is_nan(green_bits) | is_nan(blue_bits);
      black    = any_nan | max_bits[31] | (max_bits < THRESH_BITS)
               | (max_bits >= POS_INF_BITS);
      max_field = max_bits[30:23];
   end

endmodule

FILE: sv/rgbe_lane.sv
// one component lane: scale by 255, then round and clamp over two stages
module rgbe_lane import rgbe_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [31:0]   comp_bits,
   input  logic [7:0]    max_field,
   output logic [7:0]    mantissa
);

   logic [31:0] prod_ff, prod_in;
   logic [3:0]  dist_ff, dist_in;
   logic        zero_ff, zero_in;
   logic [7:0]  mant_ff, mant_in;

   logic [7:0]  eff;
   logic [23:0] sig;
   logic [8:0]  diff;
   logic [32:0] sum;
   logic [32:0] res;
   logic [5:0]  sh;

   always_comb begin
      eff     = (comp_bits[30:23] == 8'd0) ? 8'd1 : comp_bits[30:23];
      sig     = {(comp_bits[30:23] != 8'd0), comp_bits[22:0]};
      diff    = {1'b0, max_field} - {1'b0, eff};
      zero_in = comp_bits[31] | diff[8] | (diff[7:4] != 4'd0);
      dist_in = diff[3:0];
      prod_in = {8'd0, sig} * 32'd255;
   end

   always_comb begin
      sh  = 6'd24 + {2'b00, dist_ff};
      sum = {1'b0, prod_ff} + (33'd1 << (sh - 6'd1));
      res = sum >> sh;
      if (zero_ff) begin
         mant_in = 8'd0;
      end else if (res[32:8] != 25'd0) begin
         mant_in = 8'd255;
      end else begin
         mant_in = res[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff <= prod_in;
         dist_ff <= dist_in;
         zero_ff <= zero_in;
         mant_ff <= mant_in;
      end
   end

   assign mantissa = mant_ff;

endmodule

FILE: sv/float_to_rgbe_encoder.sv
// top level of the rgbe shared exponent encoder
//  channel | ports                          | direction
//  req     | req_valid req_ready req_*_bits | in, one pixel per transfer
//  rsp     | rsp_valid rsp_ready rsp_*      | out, four bytes per transfer
// rsp_valid rises once the request transfer has passed the s1, s2 and s3 valid registers
// one pixel per cycle sustained while rsp_ready holds; the three register stages advance together
// a stalled result holds every stage and drops req_ready; nothing is lost
// synchronous reset clears the valid bits only
module float_to_rgbe_encoder import rgbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_red_bits,
   input  logic [31:0] req_green_bits,
   input  logic [31:0] req_blue_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_mantissa,
   output logic [7:0]  rsp_green_mantissa,
   output logic [7:0]  rsp_blue_mantissa,
   output logic [7:0]  rsp_shared_exponent
);

   pipe_ctrl_type ctrl;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [31:0] red_ff, green_ff, blue_ff;
   logic [7:0]  field1_ff, field2_ff;
   logic        black1_ff, black2_ff, black3_ff;
   logic [7:0]  exp_ff, exp_in;
   logic [7:0]  max_field;
   logic        black;
   logic [7:0]  red_mant, green_mant, blue_mant;

   assign ctrl.advance = ~(s3_valid_ff & ~rsp_ready);
   assign req_ready    = ctrl.advance;

   rgbe_max u_max (
      .red_bits  (req_red_bits),
      .green_bits(req_green_bits),
      .blue_bits (req_blue_bits),
      .max_field (max_field),
      .black     (black)
   );

   rgbe_lane u_red   (.clock(clock), .ctrl(ctrl), .comp_bits(red_ff),
                      .max_field(field1_ff), .mantissa(red_mant));
   rgbe_lane u_green (.clock(clock), .ctrl(ctrl), .comp_bits(green_ff),
                      .max_field(field1_ff), .mantissa(green_mant));
   rgbe_lane u_blue  (.clock(clock), .ctrl(ctrl), .comp_bits(blue_ff),
                      .max_field(field1_ff), .mantissa(blue_mant));

   assign exp_in = (field2_ff >= 8'd253) ? 8'd255 : (field2_ff + 8'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         red_ff    <= req_red_bits;
         green_ff  <= req_green_bits;
         blue_ff   <= req_blue_bits;
         field1_ff <= max_field;
         black1_ff <= black;
         field2_ff <= field1_ff;
         black2_ff <= black1_ff;
         black3_ff <= black2_ff;
         exp_ff    <= exp_in;
      end
   end

   assign rsp_valid           = s3_valid_ff;
   assign rsp_red_mantissa    = black3_ff ? 8'd0 : red_mant;
   assign rsp_green_mantissa  = black3_ff ? 8'd0 : green_mant;
   assign rsp_blue_mantissa   = black3_ff ? 8'd0 : blue_mant;
   assign rsp_shared_exponent = black3_ff ? 8'd0 : exp_ff;

   // black pixel gives all zero bytes
   a_black_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shared_exponent == 8'd0 |->
         rsp_red_mantissa == 8'd0 && rsp_green_mantissa == 8'd0
         && rsp_blue_mantissa == 8'd0)
      else $error("black pixel with non-zero mantissa");

   a_exp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shared_exponent != 8'd0 |->
         rsp_shared_exponent >= MIN_EXP_BYTE)
      else $error("exponent below threshold");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.advance |=> $stable(s2_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved during stall");

endmodule
